[rtl/core/sus_pkg.sv]
// shared types and codes for the sorted unique key set
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

  localparam int CMD_W    = 2;
  localparam int IN_KEY_W = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_REMOVE   = 2'd3
  } sus_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISSING  = 3'd3,
    ST_EMPTY    = 3'd4
  } sus_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_UPD
  } sus_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IN_KEY_W-1:0] key;
  } sus_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                present;
    logic [IN_KEY_W-1:0] out_key;
    logic [COUNT_W-1:0]  entry_count;
  } sus_out_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;
    logic shift_up;
    logic shift_down;
  } sus_ctl_t;

endpackage

`default_nettype wire

[rtl/core/sus_cell.sv]
// one slot of the sorted chain: stored key, compare flags, neighbor shift
`timescale 1ns / 1ps
`default_nettype none

module sus_cell #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 7,
  parameter int INDEX     = 0
) (
  input  wire                    clk,
  input  wire sus_pkg::sus_ctl_t ctl,
  input  wire  [CNT_W-1:0]       count,
  input  wire  [KEY_WIDTH-1:0]   cmd_key,
  input  wire  [KEY_WIDTH-1:0]   left_key,
  input  wire                    left_above,
  input  wire  [KEY_WIDTH-1:0]   right_key,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic                   above_o,
  output logic                   eq_o,
  output logic [KEY_WIDTH-1:0]   top_key_o
);
  import sus_pkg::*;

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NEXT = CNT_W'(INDEX + 1);

  logic [KEY_WIDTH-1:0] key_r;
  logic                 above_r;
  logic                 ge_r;
  logic                 eq_r;
  logic                 top_r;
  logic                 occ;

  assign occ = IDX < count;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      // above: this slot sits at or past the insert position
      above_r <= !occ || (key_r > cmd_key);
      ge_r    <= occ && (key_r >= cmd_key);
      eq_r    <= occ && (key_r == cmd_key);
      top_r   <= occ && !(NEXT < count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_up && above_r) begin
      key_r <= left_above ? left_key : cmd_key;
    end else if (ctl.shift_down && ge_r) begin
      key_r <= right_key;
    end
  end

  assign key_o     = key_r;
  assign above_o   = above_r;
  assign eq_o      = eq_r;
  assign top_key_o = top_r ? key_r : '0;

endmodule

`default_nettype wire

[rtl/core/sus_reduce.sv]
// two-level registered or-tree over the cell flags and the top key
`timescale 1ns / 1ps
`default_nettype none

module sus_reduce #(
  parameter int N = 64,
  parameter int W = 32,
  parameter int G = 32
) (
  input  wire          clk,
  input  wire          hit_i [N],
  input  wire  [W-1:0] val_i [N],
  output logic         hit_o,
  output logic [W-1:0] val_o
);
  import sus_pkg::*;

  localparam int NG = (N + G - 1) / G;

  logic         grp_hit_r [NG];
  logic [W-1:0] grp_val_r [NG];
  logic         grp_hit_nxt [NG];
  logic [W-1:0] grp_val_nxt [NG];
  logic         hit_r;
  logic [W-1:0] val_r;
  logic         hit_nxt;
  logic [W-1:0] val_nxt;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_nxt[g] = 1'b0;
      grp_val_nxt[g] = '0;
      for (int j = 0; j < G; j++) begin
        if (g * G + j < N) begin
          grp_hit_nxt[g] = grp_hit_nxt[g] | hit_i[g * G + j];
          grp_val_nxt[g] = grp_val_nxt[g] | val_i[g * G + j];
        end
      end
    end
  end

  always_comb begin
    hit_nxt = 1'b0;
    val_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      hit_nxt = hit_nxt | grp_hit_r[g];
      val_nxt = val_nxt | grp_val_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_val_r <= grp_val_nxt;
    hit_r     <= hit_nxt;
    val_r     <= val_nxt;
  end

  assign hit_o = hit_r;
  assign val_o = val_r;

endmodule

`default_nettype wire

[rtl/core/sorted_unique_key_set.sv]
// top level: sequencer, chain of key cells, reduction tree and result register
//
//   channel | ports                        | word
//   --------+------------------------------+------------------------------
//   input   | in_valid, in_stall, in_word  | command, key
//   result  | out_valid, out_stall, out_word | status, present, out_key,
//           |                              | entry_count
//
// a command passes from acceptance to its result through a compare pass in
// every cell, two levels of the registered or-tree, then one shift step
// along the chain. one command is in flight at a time, so a new word is taken
// only once the sequencer is back in idle.
// rst_n clears the key count and the sequencer; the cell contents are not reset.
// a held result blocks the next command: no new word is taken while the
// result register waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_key_set #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire sus_pkg::sus_in_t in_word,
  output logic                  out_valid,
  input  wire                   out_stall,
  output sus_pkg::sus_out_t     out_word
);
  import sus_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  sus_state_t           state_r, state_nxt;
  sus_cmd_t             cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r;
  sus_out_t             out_r, res_nxt;
  sus_ctl_t             ctl;
  logic                 in_acc;
  logic                 out_acc;

  logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
  logic                 cell_above [CAPACITY];
  logic                 cell_eq [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_top [CAPACITY];
  logic                 hit;
  logic [KEY_WIDTH-1:0] top_key;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] lk;
    logic                 la;
    logic [KEY_WIDTH-1:0] rk;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign la = 1'b0;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign la = cell_above[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
    end else begin : g_inner
      assign rk = cell_key[i+1];
    end
    sus_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .CNT_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (cnt_r),
      .cmd_key   (key_r),
      .left_key  (lk),
      .left_above(la),
      .right_key (rk),
      .key_o     (cell_key[i]),
      .above_o   (cell_above[i]),
      .eq_o      (cell_eq[i]),
      .top_key_o (cell_top[i])
    );
  end

  sus_reduce #(
    .N(CAPACITY),
    .W(KEY_WIDTH),
    .G(32)
  ) u_reduce (
    .clk  (clk),
    .hit_i(cell_eq),
    .val_i(cell_top),
    .hit_o(hit),
    .val_o(top_key)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RED1;
      S_RED1: state_nxt = S_RED2;
      S_RED2: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall       = (state_r != S_IDLE) || (out_valid_r && out_stall);
    ctl.cmp        = (state_r == S_CMP);
    ctl.shift_up   = (state_r == S_UPD) && (cmd_r == CMD_INSERT) && !hit && (cnt_r < CAP_C);
    ctl.shift_down = (state_r == S_UPD) && (cmd_r == CMD_REMOVE) && hit;
  end

  // result and count for the command in the update step
  always_comb begin
    cnt_nxt             = cnt_r;
    res_nxt.status      = ST_DONE;
    res_nxt.present     = 1'b0;
    res_nxt.out_key     = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (hit) begin
          res_nxt.status  = ST_PRESENT;
          res_nxt.present = 1'b1;
        end else if (cnt_r >= CAP_C) begin
          res_nxt.status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + ONE_C;
        end
      end
      CMD_EXTRACT: begin
        if (cnt_r == '0) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.present = 1'b1;
          res_nxt.out_key = IN_KEY_W'(top_key);
          cnt_nxt         = cnt_r - ONE_C;
        end
      end
      CMD_CONTAINS: begin
        res_nxt.present = hit;
        res_nxt.status  = hit ? ST_DONE : ST_MISSING;
      end
      CMD_REMOVE: begin
        if (hit) begin
          res_nxt.present = 1'b1;
          cnt_nxt         = cnt_r - ONE_C;
        end else begin
          res_nxt.status = ST_MISSING;
        end
      end
      default: res_nxt.status = ST_DONE;
    endcase
    res_nxt.entry_count = COUNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= sus_cmd_t'(in_word.command);
      key_r <= KEY_WIDTH'(in_word.key);
    end
    if (state_r == S_UPD) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C)
    else $error("key count beyond capacity");

  a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.shift_up && ctl.shift_down))
    else $error("chain shifted both ways");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> $past(state_r == S_UPD))
    else $error("key count changed outside update step");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result raised outside update step");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CMP)
    else $error("accepted word did not start a compare pass");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the sorted unique key set
`timescale 1ns / 1ps

module tb_top;
  import sus_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int KEY_W        = 32;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 40;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sus_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  sus_out_t out_word;

  sorted_unique_key_set #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // shadow copy of the set, updated as each command word is accepted
  logic [KEY_W-1:0] model_keys [CAPACITY];
  int               model_count;
  sus_out_t         pending_results[$];

  bit tx_idle_on;
  bit rx_idle_on;
  int hold_req;
  int error_count;
  int results_checked;
  int cycle_count;
  int cmd_total [4];
  int peak_fill;
  int full_rejects;
  int empty_extracts;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int locate_key(input logic [KEY_W-1:0] k, output bit hit);
    hit = 1'b0;
    for (int i = 0; i < model_count; i++) begin
      if (model_keys[i] == k) begin
        hit = 1'b1;
        return i;
      end
      if (model_keys[i] > k) return i;
    end
    return model_count;
  endfunction

  function automatic sus_out_t apply_set_command(input sus_in_t w);
    sus_out_t r;
    int       pos;
    bit       hit;
    r = '0;
    case (sus_cmd_t'(w.command))
      CMD_INSERT: begin
        pos = locate_key(w.key, hit);
        if (hit) begin
          r.status  = ST_PRESENT;
          r.present = 1'b1;
        end else if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = w.key;
          model_count++;
          r.status = ST_DONE;
        end
      end
      CMD_EXTRACT: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          model_count--;
          r.out_key = model_keys[model_count];
          r.present = 1'b1;
          r.status  = ST_DONE;
        end
      end
      CMD_CONTAINS: begin
        pos = locate_key(w.key, hit);
        r.present = hit;
        r.status  = hit ? ST_DONE : ST_MISSING;
      end
      default: begin
        pos = locate_key(w.key, hit);
        if (hit) begin
          r.present = 1'b1;
          for (int i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
          model_count--;
          r.status = ST_DONE;
        end else begin
          r.status = ST_MISSING;
        end
      end
    endcase
    r.entry_count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // bias keys toward hits, neighbors of held keys and corner values
  function automatic logic [KEY_W-1:0] pick_key();
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 30 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
    if (r < 40 && model_count > 0) begin
      k = model_keys[$urandom_range(0, model_count - 1)];
      return $urandom_range(0, 1) ? k + 1 : k - 1;
    end
    if (r < 60) return $urandom_range(0, 95);
    if (r < 67) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_word(input sus_cmd_t cmd, input logic [KEY_W-1:0] key);
    int       gap;
    sus_in_t  w;
    sus_out_t r;
    w.command = cmd;
    w.key     = key;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = apply_set_command(w);
    pending_results.push_back(r);
    cmd_total[cmd]++;
    if (model_count > peak_fill) peak_fill = model_count;
    if (r.status == ST_FULL) full_rejects++;
    if (r.status == ST_EMPTY) empty_extracts++;
  endtask

  // lowers valid and waits out every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_word(CMD_EXTRACT,  32'h1234_5678);  // empty set
    send_word(CMD_REMOVE,   32'd5);
    send_word(CMD_CONTAINS, 32'd0);
    send_word(CMD_INSERT,   32'h8000_0000);
    send_word(CMD_INSERT,   32'h0000_0000);
    send_word(CMD_INSERT,   32'hFFFF_FFFF);
    send_word(CMD_INSERT,   32'h7FFF_FFFF);
    send_word(CMD_INSERT,   32'h0000_0001);
    send_word(CMD_INSERT,   32'h0000_0000);  // duplicate at the bottom
    send_word(CMD_INSERT,   32'hFFFF_FFFF);  // duplicate at the top
    send_word(CMD_CONTAINS, 32'hFFFF_FFFF);
    send_word(CMD_CONTAINS, 32'h0000_0002);
    send_word(CMD_CONTAINS, 32'h0000_0000);
    send_word(CMD_REMOVE,   32'h8000_0000);  // middle of the set
    send_word(CMD_REMOVE,   32'h8000_0000);
    send_word(CMD_REMOVE,   32'h0000_0000);  // front of the set
    send_word(CMD_EXTRACT,  32'h0);
    send_word(CMD_REMOVE,   32'hFFFF_FFFE);
    send_word(CMD_EXTRACT,  32'hFFFF_FFFF);
    send_word(CMD_EXTRACT,  32'h0);
    send_word(CMD_EXTRACT,  32'h0);          // empty again
    send_word(CMD_INSERT,   32'hAAAA_5555);
    send_word(CMD_INSERT,   32'h5555_AAAA);
    send_word(CMD_REMOVE,   32'h5555_AAAA);
    send_word(CMD_EXTRACT,  32'h0);
  endtask

  // fill to capacity, poke the full set, then empty it again
  task automatic test_fill_and_drain(input bit ascending);
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] stride;
    logic [KEY_W-1:0] k;
    int               j;
    tx_idle_on = $urandom_range(0, 1);
    rx_idle_on = $urandom_range(0, 1);
    base   = $urandom() & 32'h0FFF_FFFF;
    stride = $urandom_range(1, 1000);
    for (int i = 0; i < CAPACITY; i++) begin
      j = ascending ? i : CAPACITY - 1 - i;
      send_word(CMD_INSERT, base + j * stride);
    end
    send_word(CMD_INSERT, base + CAPACITY * stride);   // new key, no room
    send_word(CMD_INSERT, base + 5 * stride);          // held key, full set
    send_word(CMD_CONTAINS, base + (CAPACITY - 1) * stride);
    k = base + 17 * stride;
    send_word(CMD_REMOVE, k);
    send_word(CMD_INSERT, k);
    if (ascending) begin
      while (model_count > 0) send_word(CMD_EXTRACT, $urandom());
    end else begin
      while (model_count > 0) send_word(CMD_REMOVE, model_keys[$urandom_range(0, model_count - 1)]);
    end
    send_word(CMD_EXTRACT, $urandom());
  endtask

  // receiver holds off while the sender offers words back to back, then the sender waits for all results
  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 200;
    for (int i = 0; i < 30; i++) begin
      send_word(sus_cmd_t'($urandom_range(0, 3)), pick_key());
    end
    wait_drained();
    rx_idle_on = 1'b1;
    for (int i = 0; i < 10; i++) send_word(CMD_INSERT, pick_key());
  endtask

  task automatic test_random_mix(input int n_items);
    int       done;
    int       phase_len;
    int       profile;
    int       r;
    sus_cmd_t cmd;
    done = 0;
    while (done < n_items) begin
      phase_len  = $urandom_range(40, 160);
      profile    = $urandom_range(0, 2);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len && done < n_items; i++) begin
        r = $urandom_range(0, 99);
        case (profile)
          0:       cmd = (r < 60) ? CMD_INSERT : (r < 70) ? CMD_EXTRACT :
                         (r < 85) ? CMD_CONTAINS : CMD_REMOVE;  // grow
          1:       cmd = (r < 20) ? CMD_INSERT : (r < 55) ? CMD_EXTRACT :
                         (r < 70) ? CMD_CONTAINS : CMD_REMOVE;  // shrink
          default: cmd = (r < 35) ? CMD_INSERT : (r < 50) ? CMD_EXTRACT :
                         (r < 75) ? CMD_CONTAINS : CMD_REMOVE;  // churn
        endcase
        send_word(cmd, pick_key());
        done++;
      end
    end
  endtask

  // result side stall driver, also serves long hold-off requests
  initial begin : result_stall_gen
    bit val;
    int len;
    out_stall <= 1'b0;
    forever begin
      if (hold_req > 0) begin
        val      = 1'b1;
        len      = hold_req;
        hold_req = 0;
      end else if (!rx_idle_on) begin
        val = 1'b0;
        len = 1;
      end else begin
        val = ($urandom_range(0, 2) == 0);
        len = val ? pick_gap() + 1 : $urandom_range(1, 6);
      end
      out_stall <= val;
      repeat (len) @(posedge clk);
    end
  end

  initial begin : result_checker
    sus_out_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result word %h", out_word));
        end else begin
          want = pending_results.pop_front();
          if (out_word.status !== want.status || out_word.present !== want.present ||
              out_word.out_key !== want.out_key ||
              out_word.entry_count !== want.entry_count) begin
            flag_error($sformatf(
              "result %0d: status %0d/%0d present %0b/%0b key %h/%h count %0d/%0d (exp/act)",
              results_checked, want.status, out_word.status, want.present, out_word.present,
              want.out_key, out_word.out_key, want.entry_count, out_word.entry_count));
          end
        end
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_seq
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    model_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain(1'b1);
    test_fill_and_drain(1'b0);
    test_back_pressure();
    test_random_mix(1120);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands: %0d insert, %0d extract, %0d contains, %0d remove; %0d checked",
             cmd_total[0] + cmd_total[1] + cmd_total[2] + cmd_total[3], cmd_total[CMD_INSERT],
             cmd_total[CMD_EXTRACT], cmd_total[CMD_CONTAINS], cmd_total[CMD_REMOVE],
             results_checked);
    $display("peak fill %0d of %0d, %0d inserts refused when full, %0d extracts on empty set",
             peak_fill, CAPACITY, full_rejects, empty_extracts);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
